// ===== rtl/core/mwtg_pkg.sv =====
// Shared types, register codes and the quarter-wave sine entry function
// for the tone generator. No dependencies.
package mwtg_pkg;

	localparam int unsigned PHASE_W      = 32;
	localparam int unsigned WAVE_W       = 17;
	localparam int unsigned SAMPLE_W     = 24;
	localparam int unsigned CHAN_W       = 4;
	localparam int unsigned CH_IDX_W     = 3;
	localparam int unsigned LEVEL_W      = 16;
	localparam int unsigned QUEUE_DEPTH  = 8;
	localparam int unsigned DEF_SINE_BITS = 10;
	localparam int unsigned DEF_MAX_CHANNELS = 8;
	localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;

	localparam logic [31:0] RST_PHASE_INC = 32'd39370534;
	localparam logic [15:0] RST_LEVEL     = 16'd8192;
	localparam logic [3:0]  RST_CHANNELS  = 4'd2;

	typedef enum logic [2:0] {
		WAVE_SILENCE  = 3'd0,
		WAVE_SINE     = 3'd1,
		WAVE_SQUARE   = 3'd2,
		WAVE_TRIANGLE = 3'd3,
		WAVE_SAW      = 3'd4
	} wave_t;

	typedef enum logic [1:0] {
		REG_PHASE_INC = 2'd0,
		REG_WAVEFORM  = 2'd1,
		REG_LEVEL     = 2'd2,
		REG_CHANNELS  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] phase_increment;
		logic [2:0]  waveform;
		logic [15:0] level;
		logic [3:0]  channel_count;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                req_end;
	} frame_t;

	// sin(pi/2 * i / 2^bits) in Q1.15, Taylor series in Q30, terms truncated
	function automatic logic [15:0] sine_entry(int unsigned i, int unsigned bits);
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		longint      sum;
		longint      r;
		a    = (HALF_PI_Q30 * 64'(i)) >> bits;
		a2   = (a * a) >> 30;
		term = a;
		sum  = longint'(a);
		for (int k = 1; k <= 6; k++) begin
			term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		r = (sum + 64'sd16384) >>> 15;
		if (r > 32768)
			r = 32768;
		return 16'(r);
	endfunction

endpackage

// ===== rtl/core/mwtg_front.sv =====
// Front pipeline: accepts requests, runs the phase accumulator, evaluates
// the waveform and scales it. Depends on mwtg_pkg.
module mwtg_front #(
	parameter int unsigned SINE_TABLE_BITS = mwtg_pkg::DEF_SINE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mwtg_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          restart,
	input  logic [31:0]                   start_index,
	input  logic                          request_end,
	output logic                          push,
	output mwtg_pkg::frame_t              push_frame,
	input  logic                          pop
);
	import mwtg_pkg::*;

	localparam int unsigned TAB_LEN = (1 << SINE_TABLE_BITS) + 1;
	localparam int unsigned IDX_W   = SINE_TABLE_BITS + 1;
	localparam int unsigned OCC_W   = $clog2(QUEUE_DEPTH + 1);

	typedef logic [15:0] rom_t [TAB_LEN];

	function automatic rom_t build_rom();
		rom_t t;
		for (int unsigned i = 0; i < TAB_LEN; i++)
			t[i] = sine_entry(i, SINE_TABLE_BITS);
		return t;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [OCC_W-1:0]          occ_q;
	logic [PHASE_W-1:0]        phase_q;
	logic                      accept;
	logic [PHASE_W-1:0]        prod_lo;
	logic [PHASE_W-1:0]        phase_cur;

	logic                      v_s1, end_s1;
	logic [PHASE_W-1:0]        phase_s1;

	logic                      v_s2, end_s2, neg_s2, sq_pos_s2;
	logic [15:0]               rom_s2;
	logic signed [WAVE_W-1:0]  tri_s2, saw_s2;

	logic                      v_s3, end_s3;
	logic signed [WAVE_W-1:0]  wave_s3;

	logic                      v_s4, end_s4;
	logic [SAMPLE_W-1:0]       sample_s4;

	logic [IDX_W-1:0]          idx_raw, idx;
	logic signed [33:0]        p_ext, t_mid, t_hi, saw_d;
	logic signed [WAVE_W-1:0]  tri_val, wave_sel;
	logic signed [32:0]        mult;
	logic signed [32:0]        scaled;
	logic [SAMPLE_W-1:0]       sat;

	assign in_ready = occ_q < OCC_W'(QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (accept && !pop) begin
			occ_q <= occ_q + 1'b1;
		end else if (!accept && pop) begin
			occ_q <= occ_q - 1'b1;
		end
	end

	// Stage 1: phase accumulator
	assign prod_lo   = start_index * cfg.phase_increment;
	assign phase_cur = restart ? prod_lo : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept)
				phase_q <= phase_cur + cfg.phase_increment;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			phase_s1 <= phase_cur;
			end_s1   <= request_end;
		end
	end

	// Stage 2: table read and direct waveforms
	assign idx_raw = {1'b0, phase_s1[29 -: SINE_TABLE_BITS]};
	assign idx     = phase_s1[30] ? (IDX_W'(1 << SINE_TABLE_BITS) - idx_raw) : idx_raw;

	assign p_ext = $signed({2'b00, phase_s1});
	assign t_mid = 34'sh080000000 - p_ext;
	assign t_hi  = p_ext - 34'sh100000000;
	assign saw_d = p_ext - 34'sh080000000;

	always_comb begin
		if (phase_s1 <= 32'h40000000)
			tri_val = WAVE_W'(phase_s1 >> 15);
		else if (phase_s1 <= 32'hC0000000)
			tri_val = WAVE_W'(t_mid >>> 15);
		else
			tri_val = WAVE_W'(t_hi >>> 15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		rom_s2    <= SINE_ROM[idx];
		neg_s2    <= phase_s1[31];
		sq_pos_s2 <= phase_s1 <= 32'h80000000;
		tri_s2    <= tri_val;
		saw_s2    <= WAVE_W'(saw_d >>> 16);
		end_s2    <= end_s1;
	end

	// Stage 3: waveform select
	always_comb begin
		case (cfg.waveform)
			WAVE_SINE:     wave_sel = neg_s2 ? -$signed({1'b0, rom_s2}) : $signed({1'b0, rom_s2});
			WAVE_SQUARE:   wave_sel = sq_pos_s2 ? 17'sd32768 : -17'sd32768;
			WAVE_TRIANGLE: wave_sel = tri_s2;
			WAVE_SAW:      wave_sel = saw_s2;
			default:       wave_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		wave_s3 <= wave_sel;
		end_s3  <= end_s2;
	end

	// Stage 4: gain, floor shift to Q3.20, saturate
	assign mult   = 33'(wave_s3) * 33'($signed(cfg.level));
	assign scaled = mult >>> 8;

	always_comb begin
		if (scaled > 33'sd8388607)
			sat = 24'h7FFFFF;
		else if (scaled < -33'sd8388608)
			sat = 24'h800000;
		else
			sat = scaled[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		sample_s4 <= sat;
		end_s4    <= end_s3;
	end

	assign push               = v_s4;
	assign push_frame.sample  = sample_s4;
	assign push_frame.req_end = end_s4;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(QUEUE_DEPTH))
		else $error("frame credit count above queue depth");

endmodule

// ===== rtl/core/mwtg_queue.sv =====
// Short frame queue between the front pipeline and the channel sequencer.
// Depends on mwtg_pkg.
module mwtg_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mwtg_pkg::frame_t push_frame,
	input  logic             pop,
	output logic             empty,
	output mwtg_pkg::frame_t head
);
	import mwtg_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	frame_t           entries [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = count_q == '0;
	assign head  = entries[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries[wr_ptr_q] <= push_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= PTR_W'((int'(wr_ptr_q) + 1) % QUEUE_DEPTH);
			if (pop)
				rd_ptr_q <= PTR_W'((int'(rd_ptr_q) + 1) % QUEUE_DEPTH);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (!push && pop)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q != CNT_W'(QUEUE_DEPTH))
		else $error("frame queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("frame queue underflow");

endmodule

// ===== rtl/core/mwtg_back.sv =====
// Channel sequencer: replicates each queued frame into one item per channel
// through a registered output stage. Depends on mwtg_pkg.
module mwtg_back #(
	parameter int unsigned MAX_CHANNELS = mwtg_pkg::DEF_MAX_CHANNELS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mwtg_pkg::cfg_t                 cfg,
	input  logic                           empty,
	input  mwtg_pkg::frame_t               head,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mwtg_pkg::SAMPLE_W-1:0]  sample,
	output logic [mwtg_pkg::CH_IDX_W-1:0]  channel_index,
	output logic                           last_of_frame,
	output logic                           end_of_request
);
	import mwtg_pkg::*;

	logic                active_q;
	logic [CHAN_W-1:0]   next_ch_q;
	logic [SAMPLE_W-1:0] frm_sample_q;
	logic                frm_end_q;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [CH_IDX_W-1:0] ch_q;
	logic                last_q, end_q;

	logic [CHAN_W-1:0]   n_eff;
	logic                load;
	logic                cont_last;

	always_comb begin
		if (cfg.channel_count == '0)
			n_eff = CHAN_W'(1);
		else if (int'(cfg.channel_count) > MAX_CHANNELS)
			n_eff = CHAN_W'(MAX_CHANNELS);
		else
			n_eff = cfg.channel_count;
	end

	assign load      = !out_valid_q || out_ready;
	assign pop       = load && !active_q && !empty;
	assign cont_last = next_ch_q == n_eff - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
			next_ch_q   <= '0;
		end else if (load) begin
			if (active_q) begin
				out_valid_q <= 1'b1;
				active_q    <= !cont_last;
				next_ch_q   <= next_ch_q + 1'b1;
			end else if (!empty) begin
				out_valid_q <= 1'b1;
				active_q    <= n_eff != CHAN_W'(1);
				next_ch_q   <= CHAN_W'(1);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (active_q) begin
				sample_q <= frm_sample_q;
				ch_q     <= next_ch_q[CH_IDX_W-1:0];
				last_q   <= cont_last;
				end_q    <= cont_last && frm_end_q;
			end else if (!empty) begin
				frm_sample_q <= head.sample;
				frm_end_q    <= head.req_end;
				sample_q     <= head.sample;
				ch_q         <= '0;
				last_q       <= n_eff == CHAN_W'(1);
				end_q        <= (n_eff == CHAN_W'(1)) && head.req_end;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign sample         = sample_q;
	assign channel_index  = ch_q;
	assign last_of_frame  = last_q;
	assign end_of_request = end_q;

	a_active_shows: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> out_valid_q)
		else $error("frame in progress without an item on the output");

endmodule

// ===== rtl/core/multi_waveform_tone_generator.sv =====
// Tone generator top level: configuration registers, front pipeline,
// frame queue and channel sequencer. Depends on mwtg_pkg and all mwtg_* modules.
//
// Each accepted input item produces one sample frame: the sample is emitted
// once per channel, one output item per cycle while m_tready is high, with
// channel_index counting up from zero and tlast on the final copy. The front
// pipeline takes a new item every cycle while s_tready is high and writes its
// frame to the queue after the phase, table, select and gain stages; the first
// copy is then registered in the sequencer output stage, which emits N items
// per input item, N being the effective channel count (1 to MAX_CHANNELS). Up
// to eight frames may wait in the front pipeline and queue, one more in the
// sequencer. The user must write registers through the APB port only while the
// stream is idle; the block does not enforce this. No clearing pass after reset.
module multi_waveform_tone_generator #(
	parameter int unsigned SINE_TABLE_BITS = mwtg_pkg::DEF_SINE_BITS,
	parameter int unsigned MAX_CHANNELS    = mwtg_pkg::DEF_MAX_CHANNELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] start_index
	input  logic [0:0]  s_tuser,   // [0] restart
	input  logic        s_tlast,   // request_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [23:0] sample
	output logic [3:0]  m_tuser,   // [2:0] channel_index, [3] end_of_request
	output logic        m_tlast,   // last_of_frame
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mwtg_pkg::*;

	cfg_t   cfg_q;
	logic   wr_en;
	frame_t push_frame, head;
	logic   push, pop, empty;
	logic   m_end;
	logic [CH_IDX_W-1:0] m_ch;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_increment <= RST_PHASE_INC;
			cfg_q.waveform        <= WAVE_SINE;
			cfg_q.level           <= RST_LEVEL;
			cfg_q.channel_count   <= RST_CHANNELS;
		end else if (wr_en) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_PHASE_INC: cfg_q.phase_increment <= pwdata;
				REG_WAVEFORM:  cfg_q.waveform        <= pwdata[2:0];
				REG_LEVEL:     cfg_q.level           <= pwdata[15:0];
				REG_CHANNELS:  cfg_q.channel_count   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_PHASE_INC: prdata = cfg_q.phase_increment;
			REG_WAVEFORM:  prdata = {29'd0, cfg_q.waveform};
			REG_LEVEL:     prdata = {16'd0, cfg_q.level};
			REG_CHANNELS:  prdata = {28'd0, cfg_q.channel_count};
			default:       prdata = '0;
		endcase
	end

	mwtg_front #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.restart    (s_tuser[0]),
		.start_index(s_tdata),
		.request_end(s_tlast),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop)
	);

	mwtg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_frame(push_frame),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	mwtg_back #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.empty         (empty),
		.head          (head),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.sample        (m_tdata),
		.channel_index (m_ch),
		.last_of_frame (m_tlast),
		.end_of_request(m_end)
	);

	assign m_tuser = {m_end, m_ch};

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for the multi-waveform tone generator: directed table, then random phases.
// Expected samples come from a local phase accumulator and waveform predictor.
// Depends on mwtg_pkg and multi_waveform_tone_generator.
module testbench;
	import mwtg_pkg::*;

	localparam int SINE_BITS  = 10;
	localparam int MAX_CH     = 8;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 8;

	typedef struct packed {
		logic [23:0] sample;
		logic [2:0]  chan;
		logic        last;
		logic        eor;
	} chan_copy_t;

	typedef struct {
		bit          wr;
		logic [31:0] inc;
		logic [2:0]  wave;
		logic [15:0] lvl;
		logic [3:0]  ch;
		logic        restart;
		logic [31:0] idx;
		logic        req_end;
		bit          typed;
		int          exp_sample;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] start_index
	logic [0:0]  s_tuser;   // [0] restart
	logic        s_tlast;   // request_end
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [23:0] sample
	logic [3:0]  m_tuser;   // [2:0] channel_index, [3] end_of_request
	logic        m_tlast;   // last_of_frame
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          sine_lut [0:(1 << SINE_BITS)];
	logic [31:0] tone_phase;
	logic [31:0] reg_inc;
	logic [2:0]  reg_wave;
	logic [15:0] reg_level;
	logic [3:0]  reg_chans;

	chan_copy_t  pending_copies [$];
	chan_copy_t  got_copy;
	chan_copy_t  want_copy;
	int          bad_copies;
	int          stall_cycles;
	bit          hold_off_req;
	bit          rcv_idle_en;
	row_t        plan [$];

	multi_waveform_tone_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Q1.15 quarter-wave entry, Taylor series in Q30 with truncated terms
	function automatic int quarter_sine(int unsigned i);
		longint unsigned ang;
		longint unsigned ang2;
		longint unsigned term;
		longint          acc;
		longint          r;
		ang  = (64'd1686629713 * i) >> SINE_BITS;
		ang2 = (ang * ang) >> 30;
		term = ang;
		acc  = longint'(ang);
		for (int k = 1; k <= 6; k++) begin
			term = ((term * ang2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		r = (acc + 64'sd16384) >>> 15;
		if (r > 32768)
			r = 32768;
		return int'(r);
	endfunction

	function automatic longint tone_wave(logic [31:0] p);
		logic [SINE_BITS:0] ix;
		longint             v;
		longint             pl;
		pl = longint'({32'b0, p});
		case (reg_wave)
			WAVE_SINE: begin
				ix = (SINE_BITS + 1)'(p[29:0] >> (30 - SINE_BITS));
				if (p[30])
					ix = (SINE_BITS + 1)'(1 << SINE_BITS) - ix;
				v = sine_lut[ix];
				if (p[31])
					v = -v;
			end
			WAVE_SQUARE: v = (p <= 32'h80000000) ? 64'sd32768 : -64'sd32768;
			WAVE_TRIANGLE: begin
				if (p <= 32'h40000000)
					v = pl >>> 15;
				else if (p <= 32'hC0000000)
					v = (64'sh80000000 - pl) >>> 15;
				else
					v = (pl - 64'sh100000000) >>> 15;
			end
			WAVE_SAW: v = (pl - 64'sh80000000) >>> 16;
			default: v = 0;
		endcase
		return v;
	endfunction

	task automatic predict_frame(logic rs, logic [31:0] ix, logic re, bit typed, int typed_val);
		longint     lvl;
		longint     s;
		int         n;
		chan_copy_t cc;
		if (rs)
			tone_phase = ix * reg_inc;
		lvl = longint'($signed(reg_level));
		s = (tone_wave(tone_phase) * lvl) >>> 8;
		if (s > 8388607)
			s = 8388607;
		if (s < -8388608)
			s = -8388608;
		if (typed)
			s = typed_val;
		n = reg_chans;
		if (n < 1)
			n = 1;
		if (n > MAX_CH)
			n = MAX_CH;
		for (int c = 0; c < n; c++) begin
			cc.sample = s[23:0];
			cc.chan   = c[2:0];
			cc.last   = (c == n - 1);
			cc.eor    = (c == n - 1) && re;
			pending_copies.push_back(cc);
		end
		tone_phase = tone_phase + reg_inc;
	endtask

	// called just after a falling edge, returns at a falling edge with nothing driven there
	task automatic apb_write(reg_idx_t r, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (r)
			REG_PHASE_INC: reg_inc   = v;
			REG_WAVEFORM:  reg_wave  = v[2:0];
			REG_LEVEL:     reg_level = v[15:0];
			REG_CHANNELS:  reg_chans = v[3:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_tone(logic [31:0] inc, logic [2:0] wave, logic [15:0] lvl,
			logic [3:0] ch);
		apb_write(REG_PHASE_INC, inc);
		apb_write(REG_WAVEFORM, {29'b0, wave});
		apb_write(REG_LEVEL, {16'b0, lvl});
		apb_write(REG_CHANNELS, {28'b0, ch});
	endtask

	task automatic wait_drained();
		while (pending_copies.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic send_item(logic rs, logic [31:0] ix, logic re, bit typed, int typed_val);
		s_tvalid <= 1'b1;
		s_tuser  <= rs;
		s_tdata  <= ix;
		s_tlast  <= re;
		do @(posedge clk); while (!s_tready);
		predict_frame(rs, ix, re, typed, typed_val);
		@(negedge clk);
	endtask

	task automatic sender_gap(bit en);
		if (en && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
	endtask

	// receiver: random stall bursts, or one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				m_tready <= 1'b0;
				hold_off_req = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (rcv_idle_en && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_copy.sample = m_tdata;
				got_copy.chan   = m_tuser[2:0];
				got_copy.last   = m_tlast;
				got_copy.eor    = m_tuser[3];
				if (pending_copies.size() == 0) begin
					bad_copies++;
					if (bad_copies <= 10)
						$display("unexpected item: sample %h ch %0d last %b eor %b",
							got_copy.sample, got_copy.chan, got_copy.last, got_copy.eor);
				end else begin
					want_copy = pending_copies.pop_front();
					if (got_copy !== want_copy) begin
						bad_copies++;
						if (bad_copies <= 10)
							$display("mismatch: exp %h ch %0d last %b eor %b, got %h ch %0d %b %b",
								want_copy.sample, want_copy.chan, want_copy.last,
								want_copy.eor, got_copy.sample, got_copy.chan,
								got_copy.last, got_copy.eor);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(psel && penable && pwrite && pready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		row_t        r;
		logic [31:0] inc;
		logic [2:0]  wave;
		logic [15:0] lvl;
		logic [3:0]  ch;
		bit          snd_idle_en;

		for (int i = 0; i <= (1 << SINE_BITS); i++)
			sine_lut[i] = quarter_sine(i);
		tone_phase   = '0;
		reg_inc      = RST_PHASE_INC;
		reg_wave     = WAVE_SINE;
		reg_level    = RST_LEVEL;
		reg_chans    = RST_CHANNELS;
		bad_copies   = 0;
		stall_cycles = 0;
		hold_off_req = 1'b0;
		rcv_idle_en  = 1'b1;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		s_tlast  = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;

		// wr, inc, wave, level, channels, restart, index, end, typed, sample
		plan.push_back('{0, 0, 0, 0, 0, 0, 32'h0, 0, 1, 0});          // reset values, phase 0
		plan.push_back('{0, 0, 0, 0, 0, 0, 32'hFFFF0000, 1, 0, 0});
		plan.push_back('{1, 32'h40000000, WAVE_SQUARE, 16'd8192, 4'd1, 1, 32'h0, 1, 1, 1048576});
		plan.push_back('{0, 0, 0, 0, 0, 0, 32'h0, 0, 1, 1048576});
		plan.push_back('{0, 0, 0, 0, 0, 0, 32'h0, 1, 1, 1048576});    // square at half cycle
		plan.push_back('{0, 0, 0, 0, 0, 0, 32'h0, 0, 1, -1048576});
		plan.push_back('{1, 32'h40000000, WAVE_TRIANGLE, 16'h7FFF, 4'd8, 1, 32'h1, 0, 1, 4194176});
		plan.push_back('{0, 0, 0, 0, 0, 0, 32'h0, 1, 1, 0});
		plan.push_back('{0, 0, 0, 0, 0, 0, 32'h0, 0, 1, -4194176});
		plan.push_back('{1, 32'h80000000, WAVE_SAW, 16'h8000, 4'd15, 1, 32'h0, 1, 1, 4194304});
		plan.push_back('{0, 0, 0, 0, 0, 0, 32'h0, 0, 1, 0});
		plan.push_back('{0, 0, 0, 0, 0, 1, 32'hFFFFFFFF, 1, 1, 0});
		plan.push_back('{1, 32'hFFFFFFFF, 3'd5, 16'd8192, 4'd0, 0, 32'h0, 1, 1, 0}); // bad code
		plan.push_back('{1, 32'hFFFFFFFF, 3'd7, 16'd8192, 4'd0, 1, 32'hA5A5A5A5, 1, 1, 0});
		plan.push_back('{1, 32'h12345678, WAVE_SILENCE, 16'h7FFF, 4'd3, 0, 32'h0, 1, 1, 0});
		plan.push_back('{1, 32'h40000000, WAVE_SINE, 16'd8192, 4'd4, 1, 32'h1, 0, 0, 0});
		plan.push_back('{0, 0, 0, 0, 0, 0, 32'h0, 0, 0, 0});
		plan.push_back('{0, 0, 0, 0, 0, 0, 32'h0, 1, 0, 0});
		plan.push_back('{0, 0, 0, 0, 0, 0, 32'h0, 0, 0, 0});
		plan.push_back('{1, 32'd39370534, WAVE_SINE, 16'h8000, 4'd6, 1, 32'hFFFFFFFF, 1, 0, 0});
		plan.push_back('{0, 0, 0, 0, 0, 0, 32'h0, 0, 0, 0});
		plan.push_back('{1, 32'd1, WAVE_SINE, 16'd1, 4'd8, 1, 32'h5A5A5A5A, 1, 0, 0});

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			r = plan[i];
			if (r.wr) begin
				s_tvalid <= 1'b0;
				wait_drained();
				program_tone(r.inc, r.wave, r.lvl, r.ch);
			end
			send_item(r.restart, r.idx, r.req_end, r.typed, r.exp_sample);
			sender_gap(1'b1);
		end

		for (int ph = 0; ph < 6; ph++) begin
			s_tvalid <= 1'b0;
			wait_drained();
			inc  = (ph == 1) ? 32'hFFFFFFFF : (ph == 4) ? 32'h0 :
				($urandom_range(0, 1) ? $urandom : $urandom_range(1, 32'h00FFFFFF));
			wave = (ph < 5) ? 3'((ph + 1) % 5) : 3'($urandom_range(0, 7));
			lvl  = (ph == 1) ? 16'h8000 : (ph == 3) ? 16'h7FFF : 16'($urandom);
			ch   = (ph == 1) ? 4'd8 : (ph == 4) ? 4'd0 : (ph == 2) ? 4'd15 :
				4'($urandom_range(0, 15));
			program_tone(inc, wave, lvl, ch);
			snd_idle_en = (ph != 2) && (ph != 5);
			rcv_idle_en = (ph != 5);
			if (ph == 2)
				hold_off_req = 1'b1;
			for (int n = 0; n < 60; n++) begin
				if (ph == 3 && n == 30) begin
					s_tvalid <= 1'b0;
					wait_drained();
				end
				send_item($urandom_range(0, 7) == 0, $urandom, $urandom_range(0, 3) == 0, 0, 0);
				sender_gap(snd_idle_en);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_copies.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (pending_copies.size() != 0)
			$display("%0d expected items never arrived", pending_copies.size());
		if (bad_copies == 0 && pending_copies.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== multi_waveform_tone_generator.f =====
rtl/core/mwtg_pkg.sv
rtl/core/mwtg_front.sv
rtl/core/mwtg_queue.sv
rtl/core/mwtg_back.sv
rtl/core/multi_waveform_tone_generator.sv
dv/testbench.sv
